// File: hdl/mbip_pkg.sv
// shared types and constants for the multi-base integer text parser
// used by every module of the block; depends on nothing
`default_nettype none

package mbip_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned OUT_WIDTH       = 32;
  localparam int unsigned CHAR_WIDTH      = 8;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_BIN = 2'd1,
    BASE_OCT = 2'd2,
    BASE_HEX = 2'd3
  } base_e;

  localparam logic [CHAR_WIDTH-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_ONE   = 8'h31;
  localparam logic [CHAR_WIDTH-1:0] CH_SEVEN = 8'h37;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_F  = 8'h46;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_B  = 8'h62;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_F  = 8'h66;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_O  = 8'h6f;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_X  = 8'h78;

  // letters a..f and A..F share a low nibble one above their rank
  localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

  typedef struct packed {
    logic negative;
    logic stopped;
    logic prefix_armed;
    logic overflowed;
  } flags_t;

  localparam flags_t FLAGS_CLEAR = '{
    negative:     1'b0,
    stopped:      1'b0,
    prefix_armed: 1'b1,
    overflowed:   1'b0
  };

endpackage

`default_nettype wire

// File: hdl/multi_base_integer_text_parser.sv
// a terminating byte passes through the input register and then the result register
// throughput: one byte per cycle while no terminating byte waits on a stalled result
// a byte stalls in the input register only if it ends a string and the result is stalled
// reset (asynchronous, active low): base decimal, accumulator and flags cleared, prefix armed
// top level of the parser; depends on mbip_pkg, mbip_step and mbip_out_reg
`default_nettype none

module multi_base_integer_text_parser #(
  parameter int unsigned VALUE_WIDTH = mbip_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [1:0]                        cfg_base_mode_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [mbip_pkg::CHAR_WIDTH-1:0]   character_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [mbip_pkg::OUT_WIDTH-1:0]  value_o,
  output logic                                   overflow_o
);

  mbip_pkg::base_e                       base_q;
  logic                                  in_valid_q, in_valid_d;
  logic [mbip_pkg::CHAR_WIDTH-1:0]       char_q;
  logic [VALUE_WIDTH-1:0]                acc_q, acc_d;
  mbip_pkg::flags_t                      flags_q, flags_d;
  logic                                  is_term;
  logic                                  out_ready;
  logic                                  advance;
  logic                                  accept;
  logic [mbip_pkg::OUT_WIDTH-1:0]        step_value;
  logic                                  step_overflow;
  logic [mbip_pkg::OUT_WIDTH-1:0]        out_value;

  // only a terminator needs room in the result register
  assign advance    = in_valid_q && (!is_term || out_ready);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= mbip_pkg::BASE_DEC;
      in_valid_q <= 1'b0;
      acc_q      <= '0;
      flags_q    <= mbip_pkg::FLAGS_CLEAR;
    end else begin
      if (cfg_we_i) base_q <= mbip_pkg::base_e'(cfg_base_mode_i);
      in_valid_q <= in_valid_d;
      if (advance) begin
        acc_q   <= acc_d;
        flags_q <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) char_q <= character_i;
  end

  mbip_step #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_step (
    .char_i     (char_q),
    .base_i     (base_q),
    .acc_i      (acc_q),
    .flags_i    (flags_q),
    .acc_o      (acc_d),
    .flags_o    (flags_d),
    .is_term_o  (is_term),
    .value_o    (step_value),
    .overflow_o (step_overflow)
  );

  mbip_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && is_term),
    .value_i    (step_value),
    .overflow_i (step_overflow),
    .ready_o    (out_ready),
    .valid_o    (out_valid_o),
    .stall_i    (out_stall_i),
    .value_o    (out_value),
    .overflow_o (overflow_o)
  );

  assign value_o = signed'(out_value);

endmodule

`default_nettype wire

// File: hdl/mbip_step.sv
// one-character update of the parser state and result formatting
// combinational only; depends on mbip_pkg
`default_nettype none

module mbip_step #(
  parameter int unsigned VALUE_WIDTH = mbip_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic [mbip_pkg::CHAR_WIDTH-1:0] char_i,
  input  wire mbip_pkg::base_e                 base_i,
  input  wire logic [VALUE_WIDTH-1:0]          acc_i,
  input  wire mbip_pkg::flags_t                flags_i,
  output logic [VALUE_WIDTH-1:0]               acc_o,
  output mbip_pkg::flags_t                     flags_o,
  output logic                                 is_term_o,
  output logic [mbip_pkg::OUT_WIDTH-1:0]       value_o,
  output logic                                 overflow_o
);

  logic                   acc_zero;
  logic                   is_space;
  logic                   is_dec;
  logic                   is_oct;
  logic                   is_lo_hex;
  logic                   is_up_hex;
  logic                   letter_hit;
  logic [3:0]             hex_digit;
  logic [VALUE_WIDTH+3:0] dec_sum;
  logic [VALUE_WIDTH-1:0] mag;

  assign is_term_o = (char_i == mbip_pkg::CH_NUL);
  assign acc_zero  = (acc_i == '0);
  assign is_space  = ((char_i >= mbip_pkg::CH_TAB) && (char_i <= mbip_pkg::CH_CR)) ||
                     (char_i == mbip_pkg::CH_SPACE);
  assign is_dec    = (char_i >= mbip_pkg::CH_ZERO) && (char_i <= mbip_pkg::CH_NINE);
  assign is_oct    = (char_i >= mbip_pkg::CH_ZERO) && (char_i <= mbip_pkg::CH_SEVEN);
  assign is_lo_hex = (char_i >= mbip_pkg::CH_LO_A) && (char_i <= mbip_pkg::CH_LO_F);
  assign is_up_hex = (char_i >= mbip_pkg::CH_UP_A) && (char_i <= mbip_pkg::CH_UP_F);
  assign hex_digit = is_dec ? char_i[3:0] : 4'(char_i[3:0] + mbip_pkg::HEX_LETTER_OFS);

  always_comb begin
    unique case (base_i)
      mbip_pkg::BASE_BIN: letter_hit = (char_i == mbip_pkg::CH_LO_B);
      mbip_pkg::BASE_OCT: letter_hit = (char_i == mbip_pkg::CH_LO_O);
      mbip_pkg::BASE_HEX: letter_hit = (char_i == mbip_pkg::CH_LO_X);
      default:            letter_hit = 1'b0;
    endcase
  end

  // acc * 10 + digit, with four spare bits to see the carry out
  assign dec_sum = ({4'b0, acc_i} << 3) + ({4'b0, acc_i} << 1) +
                   (VALUE_WIDTH + 4)'(char_i[3:0]);

  always_comb begin
    acc_o   = acc_i;
    flags_o = flags_i;
    flags_o.prefix_armed = 1'b0;
    if (is_term_o) begin
      acc_o   = '0;
      flags_o = mbip_pkg::FLAGS_CLEAR;
    end else if (flags_i.stopped) begin
      acc_o = acc_i;
    end else if (flags_i.prefix_armed && letter_hit) begin
      acc_o = acc_i;
    end else if (is_space || (char_i == mbip_pkg::CH_MINUS)) begin
      if (!acc_zero) begin
        flags_o.stopped = 1'b1;
      end else if (char_i == mbip_pkg::CH_MINUS) begin
        flags_o.negative = 1'b1;
      end
    end else if (base_i == mbip_pkg::BASE_DEC) begin
      if (!is_dec) begin
        flags_o.stopped = 1'b1;
      end else begin
        acc_o = dec_sum[VALUE_WIDTH-1:0];
        if (|dec_sum[VALUE_WIDTH+3:VALUE_WIDTH]) flags_o.overflowed = 1'b1;
      end
    end else if ((char_i == mbip_pkg::CH_ZERO) && acc_zero) begin
      flags_o.prefix_armed = 1'b1;
    end else begin
      unique case (base_i)
        mbip_pkg::BASE_BIN: begin
          if ((char_i == mbip_pkg::CH_ZERO) || (char_i == mbip_pkg::CH_ONE)) begin
            acc_o = {acc_i[VALUE_WIDTH-2:0], char_i[0]};
            if (acc_i[VALUE_WIDTH-1]) flags_o.overflowed = 1'b1;
          end
        end
        mbip_pkg::BASE_OCT: begin
          if (is_oct) begin
            acc_o = {acc_i[VALUE_WIDTH-4:0], char_i[2:0]};
            if (|acc_i[VALUE_WIDTH-1 -: 3]) flags_o.overflowed = 1'b1;
          end
        end
        default: begin
          if (is_dec || is_lo_hex || is_up_hex) begin
            acc_o = {acc_i[VALUE_WIDTH-5:0], hex_digit};
            if (|acc_i[VALUE_WIDTH-1 -: 4]) flags_o.overflowed = 1'b1;
          end
        end
      endcase
    end
  end

  // two's complement at the accumulator width, sign-extended or cut to the port
  assign mag        = flags_i.negative ? VALUE_WIDTH'(-acc_i) : acc_i;
  assign value_o    = mbip_pkg::OUT_WIDTH'(signed'(mag));
  assign overflow_o = flags_i.overflowed;

endmodule

`default_nettype wire

// File: hdl/mbip_out_reg.sv
// result register for the output channel, holds a word while stalled
// depends on mbip_pkg
`default_nettype none

module mbip_out_reg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             load_i,
  input  wire logic [mbip_pkg::OUT_WIDTH-1:0]   value_i,
  input  wire logic                             overflow_i,
  output logic                                  ready_o,
  output logic                                  valid_o,
  input  wire logic                             stall_i,
  output logic [mbip_pkg::OUT_WIDTH-1:0]        value_o,
  output logic                                  overflow_o
);

  logic                           valid_q, valid_d;
  logic [mbip_pkg::OUT_WIDTH-1:0] value_q;
  logic                           overflow_q;

  assign ready_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      value_q    <= value_i;
      overflow_q <= overflow_i;
    end
  end

  assign valid_o    = valid_q;
  assign value_o    = value_q;
  assign overflow_o = overflow_q;

endmodule

`default_nettype wire

// File: hdl/mbip_checker.sv
// port-level checks for the parser over time, attached by bind
// depends on mbip_pkg and the top level multi_base_integer_text_parser
`default_nettype none

module mbip_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic [mbip_pkg::CHAR_WIDTH-1:0]   character_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic [mbip_pkg::OUT_WIDTH-1:0]    value_o,
  input wire logic                              overflow_o
);

  // a stalled result word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(overflow_o))
    else $error("result word changed while stalled");

  // input only ever waits on a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output was free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // an accepted terminator reaches the output if the output is free once it sits in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (character_i == mbip_pkg::CH_NUL)) ##1 !out_stall_i
      |=> out_valid_o)
    else $error("terminator produced no result word");

endmodule

bind multi_base_integer_text_parser mbip_checker u_mbip_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .character_i (character_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .value_o     (value_o),
  .overflow_o  (overflow_o)
);

`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench for multi_base_integer_text_parser: strings in all four bases
// against a built-in parser model, with random idling on both sides; depends on mbip_pkg
`default_nettype none

module testbench;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_WORDS  = 56;
  localparam int HOLD_CYCLES  = 150;

  typedef struct packed {
    logic signed [mbip_pkg::OUT_WIDTH-1:0] value;
    logic                                  overflow;
  } parse_result_t;

  // parser model and the queue of results it predicts
  class int_parse_scoreboard;
    mbip_pkg::base_e base;
    logic [31:0]     acc;
    bit              negative;
    bit              halted;
    bit              armed;
    bit              overflowed;
    parse_result_t   expected_q[$];
    int              errors;
    int              results_seen;
    int              overflow_seen;
    int              negative_seen;

    function new();
      base = mbip_pkg::BASE_DEC;
      errors = 0;
      results_seen = 0;
      overflow_seen = 0;
      negative_seen = 0;
      clear_string();
    endfunction

    function void clear_string();
      acc = '0;
      negative = 1'b0;
      halted = 1'b0;
      armed = 1'b1;
      overflowed = 1'b0;
    endfunction

    function void set_base(mbip_pkg::base_e b);
      base = b;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void shift_digit(int bits, logic [31:0] digit);
      if ((acc >> (32 - bits)) != 0) overflowed = 1'b1;
      acc = (acc << bits) | digit;
    endfunction

    function void note_word(logic [7:0] ch);
      parse_result_t res;
      bit was_armed;
      logic [31:0] d;
      if (ch == mbip_pkg::CH_NUL) begin
        res.value = negative ? -acc : acc;
        res.overflow = overflowed;
        expected_q.push_back(res);
        clear_string();
        return;
      end
      was_armed = armed;
      armed = 1'b0;
      if (halted) return;
      if (was_armed && ((base == mbip_pkg::BASE_BIN && ch == mbip_pkg::CH_LO_B) ||
                        (base == mbip_pkg::BASE_OCT && ch == mbip_pkg::CH_LO_O) ||
                        (base == mbip_pkg::BASE_HEX && ch == mbip_pkg::CH_LO_X)))
        return;
      if ((ch >= mbip_pkg::CH_TAB && ch <= mbip_pkg::CH_CR) || ch == mbip_pkg::CH_SPACE ||
          ch == mbip_pkg::CH_MINUS) begin
        if (acc != 0) halted = 1'b1;
        else if (ch == mbip_pkg::CH_MINUS) negative = 1'b1;
        return;
      end
      if (base == mbip_pkg::BASE_DEC) begin
        if (ch < mbip_pkg::CH_ZERO || ch > mbip_pkg::CH_NINE) begin
          halted = 1'b1;
          return;
        end
        d = 32'(ch - mbip_pkg::CH_ZERO);
        if (acc > (32'hffff_ffff - d) / 32'd10) overflowed = 1'b1;
        acc = acc * 32'd10 + d;
        return;
      end
      // a leading zero re-arms the prefix letter
      if (ch == mbip_pkg::CH_ZERO && acc == 0) begin
        armed = 1'b1;
        return;
      end
      case (base)
        mbip_pkg::BASE_BIN: begin
          if (ch == mbip_pkg::CH_ZERO || ch == mbip_pkg::CH_ONE)
            shift_digit(1, 32'(ch - mbip_pkg::CH_ZERO));
        end
        mbip_pkg::BASE_OCT: begin
          if (ch >= mbip_pkg::CH_ZERO && ch <= mbip_pkg::CH_SEVEN)
            shift_digit(3, 32'(ch - mbip_pkg::CH_ZERO));
        end
        default: begin
          if (ch >= mbip_pkg::CH_ZERO && ch <= mbip_pkg::CH_NINE)
            shift_digit(4, 32'(ch - mbip_pkg::CH_ZERO));
          else if (ch >= mbip_pkg::CH_LO_A && ch <= mbip_pkg::CH_LO_F)
            shift_digit(4, 32'(ch - mbip_pkg::CH_LO_A + 10));
          else if (ch >= mbip_pkg::CH_UP_A && ch <= mbip_pkg::CH_UP_F)
            shift_digit(4, 32'(ch - mbip_pkg::CH_UP_A + 10));
        end
      endcase
    endfunction

    function void check_result(logic signed [mbip_pkg::OUT_WIDTH-1:0] value, logic overflow);
      parse_result_t exp_res;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: value %0d overflow %0b", value, overflow);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (value !== exp_res.value) begin
        $error("value: expected %0d, got %0d", exp_res.value, value);
        errors++;
      end
      if (overflow !== exp_res.overflow) begin
        $error("overflow: expected %0b, got %0b", exp_res.overflow, overflow);
        errors++;
      end
      if (exp_res.overflow) overflow_seen++;
      if (exp_res.value < 0) negative_seen++;
    endfunction
  endclass

  logic                                  clk_i;
  logic                                  rst_ni;
  logic                                  cfg_we_i;
  logic [1:0]                            cfg_base_mode_i;
  logic                                  in_valid_i;
  logic                                  in_stall_o;
  logic [mbip_pkg::CHAR_WIDTH-1:0]       character_i;
  logic                                  out_valid_o;
  logic                                  out_stall_i;
  logic signed [mbip_pkg::OUT_WIDTH-1:0] value_o;
  logic                                  overflow_o;

  int_parse_scoreboard sb;
  int  words_sent;
  int  strings_sent;
  bit  sender_calm;
  bit  sink_calm;

  multi_base_integer_text_parser uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_base_mode_i (cfg_base_mode_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .character_i     (character_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .value_o         (value_o),
    .overflow_o      (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] random_space();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? mbip_pkg::CH_SPACE : 8'(mbip_pkg::CH_TAB + k);
  endfunction

  function automatic logic [7:0] random_digit(mbip_pkg::base_e b);
    int k;
    case (b)
      mbip_pkg::BASE_DEC: return 8'(mbip_pkg::CH_ZERO + $urandom_range(0, 9));
      mbip_pkg::BASE_BIN: return 8'(mbip_pkg::CH_ZERO + $urandom_range(0, 1));
      mbip_pkg::BASE_OCT: return 8'(mbip_pkg::CH_ZERO + $urandom_range(0, 7));
      default: begin
        k = $urandom_range(0, 21);
        if (k < 10) return 8'(mbip_pkg::CH_ZERO + k);
        else if (k < 16) return 8'(mbip_pkg::CH_LO_A + k - 10);
        else return 8'(mbip_pkg::CH_UP_A + k - 16);
      end
    endcase
  endfunction

  function automatic logic [7:0] prefix_letter(mbip_pkg::base_e b);
    case (b)
      mbip_pkg::BASE_BIN: return mbip_pkg::CH_LO_B;
      mbip_pkg::BASE_OCT: return mbip_pkg::CH_LO_O;
      default:            return mbip_pkg::CH_LO_X;
    endcase
  endfunction

  // offer one word after a random gap and wait until it is taken
  task automatic send_word(input logic [7:0] ch);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    character_i <= ch;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(ch);
    words_sent++;
    if (ch == mbip_pkg::CH_NUL) strings_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i]);
    send_word(mbip_pkg::CH_NUL);
  endtask

  // only written once every string has come out and the pipeline has drained
  task automatic write_base(input mbip_pkg::base_e b);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i        <= 1'b1;
    cfg_base_mode_i <= b;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_base(b);
  endtask

  task automatic send_random_string(input mbip_pkg::base_e b);
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    sender_calm = ($urandom_range(0, 3) == 0);
    if (kind <= 5) begin
      repeat ($urandom_range(0, 2)) send_word(random_space());
      if ($urandom_range(0, 1)) send_word(mbip_pkg::CH_MINUS);
      if (b != mbip_pkg::BASE_DEC && $urandom_range(0, 2) == 0) begin
        send_word(mbip_pkg::CH_ZERO);
        send_word(prefix_letter(b));
      end
      repeat ($urandom_range(1, 8)) send_word(random_digit(b));
      // trailing junk: separator or stray byte, then one more digit
      if ($urandom_range(0, 4) == 0) begin
        send_word(8'($urandom_range(1, 255)));
        send_word(random_digit(b));
      end
    end else if (kind == 7 && b == mbip_pkg::BASE_HEX) begin
      // most negative value
      send_word(mbip_pkg::CH_MINUS);
      send_word(8'(mbip_pkg::CH_ZERO + 8));
      repeat (7) send_word(mbip_pkg::CH_ZERO);
    end else if (kind <= 7) begin
      // long digit runs around the 32-bit boundary
      case (b)
        mbip_pkg::BASE_DEC: n = $urandom_range(9, 11);
        mbip_pkg::BASE_BIN: n = $urandom_range(30, 34);
        mbip_pkg::BASE_OCT: n = $urandom_range(10, 12);
        default:            n = $urandom_range(7, 9);
      endcase
      if ($urandom_range(0, 1)) send_word(mbip_pkg::CH_MINUS);
      send_word(b == mbip_pkg::BASE_BIN ? mbip_pkg::CH_ONE :
                8'(mbip_pkg::CH_ZERO + $urandom_range(1, 7)));
      repeat (n - 1) send_word(random_digit(b));
    end else begin
      repeat ($urandom_range(1, 6)) send_word(8'($urandom_range(1, 255)));
    end
    send_word(mbip_pkg::CH_NUL);
  endtask

  initial begin : result_sink
    int n;
    int holds;
    holds = 0;
    sink_calm = 1'b0;
    out_stall_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
      n = sink_calm ? 0 : $urandom_range(0, 17);
      // long hold-off so the parser backs up into its input
      if (holds < 2 && sb.results_seen >= 30 + 60 * holds) begin
        n = HOLD_CYCLES;
        holds++;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(value_o, overflow_o);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    mbip_pkg::base_e b;
    sb = new();
    words_sent = 0;
    strings_sent = 0;
    sender_calm = 1'b0;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_base_mode_i <= mbip_pkg::BASE_DEC;
    in_valid_i      <= 1'b0;
    character_i     <= mbip_pkg::CH_NUL;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // decimal from reset: sign, stop on space, stop on letter, empty string
    send_text("-7 9");
    send_text("9a1");
    send_word(mbip_pkg::CH_NUL);
    // binary: zero re-arms prefix, minus while empty, bad digits skipped
    write_base(mbip_pkg::BASE_BIN);
    send_text("0b-1x1");
    // octal: prefix at string start, eight skipped
    write_base(mbip_pkg::BASE_OCT);
    send_text("o78");
    // hex: mixed case and a byte above 127
    write_base(mbip_pkg::BASE_HEX);
    send_word(mbip_pkg::CH_LO_X);
    send_word(mbip_pkg::CH_LO_F);
    send_word(mbip_pkg::CH_UP_F);
    send_word(8'hff);
    send_word(mbip_pkg::CH_NUL);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: b = mbip_pkg::BASE_HEX;
        1: b = mbip_pkg::BASE_DEC;
        2: b = mbip_pkg::BASE_BIN;
        3: b = mbip_pkg::BASE_OCT;
        default: b = mbip_pkg::base_e'($urandom_range(0, 3));
      endcase
      write_base(b);
      for (int start = words_sent; words_sent - start < PHASE_WORDS; )
        send_random_string(b);
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d words in %0d strings across all four bases", words_sent, strings_sent);
    $display("%0d results checked, %0d negative, %0d with overflow",
             sb.results_seen, sb.negative_seen, sb.overflow_seen);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
hdl/mbip_pkg.sv
hdl/mbip_step.sv
hdl/mbip_out_reg.sv
hdl/multi_base_integer_text_parser.sv
hdl/mbip_checker.sv
verif/testbench.sv
